// ----- design/rtu_gap_pkg.sv -----
// ----------------------------------------------------------------------------
// rtu_gap_pkg
// Shared types and constants of the RTU frame gap detector.
// ----------------------------------------------------------------------------
package rtu_gap_pkg;

  // Receive buffer depth; the store saturates at this many bytes
  localparam int unsigned BUF_DEPTH = 256;

  // Fixed field widths
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned TICK_W = 16;
  localparam int unsigned LEN_W  = 9;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned CFG_W  = 2;

  // Configuration register indexes
  localparam logic [CFG_W-1:0] REG_SHORT_GAP = 2'd0;
  localparam logic [CFG_W-1:0] REG_EXTRA_GAP = 2'd1;

  // Input beat commands
  typedef enum logic [CMD_W-1:0] {
    CMD_RX_BYTE  = 3'd0,
    CMD_TICK     = 3'd1,
    CMD_ARM      = 3'd2,
    CMD_DISARM   = 3'd3,
    CMD_TX_START = 3'd4
  } cmd_e;

  // Events from the gap timer for the beat being processed
  typedef struct packed {
    logic char_gap;    // 1.5 character silence reached
    logic frame_end;   // 3.5 character silence reached
    logic in_window;   // timer sits between 1.5 and 3.5 characters
  } tmr_evt_t;

  // One result beat
  typedef struct packed {
    logic              store_valid;
    logic [IDX_W-1:0]  store_index;
    logic [BYTE_W-1:0] store_byte;
    logic              char_gap_event;
    logic              frame_end_event;
    logic              frame_error_event;
    logic              overflow_flag;
    logic [LEN_W-1:0]  frame_length;
  } res_t;

endpackage

// ----- design/rtu_gap_timer.sv -----
// ----------------------------------------------------------------------------
// rtu_gap_timer
// Silence timer: restarts on every received byte, flags the 1.5 and 3.5
// character gaps on tick beats, stops on frame end or transmit start.
// ----------------------------------------------------------------------------
module rtu_gap_timer
  import rtu_gap_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,        // beat in the work stage moves on
  input  cmd_e              cmd_i,
  input  logic [TICK_W-1:0] short_gap_i,
  input  logic [TICK_W-1:0] extra_gap_i,
  output tmr_evt_t          evt_o
);

  logic              gap_phase_q, gap_phase_d;
  logic              running_q, running_d;
  logic [TICK_W-1:0] tick_count_q, tick_count_d;
  logic [TICK_W-1:0] compare_q, compare_d;
  logic [TICK_W-1:0] count_inc;
  logic              match;

  // Count wraps at 2^16, so a zero compare matches on wrap
  assign count_inc = tick_count_q + TICK_W'(1);
  assign match     = (count_inc == compare_q);

  // Next state and events
  always_comb begin
    gap_phase_d     = gap_phase_q;
    running_d       = running_q;
    tick_count_d    = tick_count_q;
    compare_d       = compare_q;
    evt_o.char_gap  = 1'b0;
    evt_o.frame_end = 1'b0;
    evt_o.in_window = gap_phase_q;
    case (cmd_i)
      CMD_RX_BYTE: begin
        tick_count_d = '0;
        compare_d    = short_gap_i;
        gap_phase_d  = 1'b0;
        running_d    = 1'b1;
      end
      CMD_TICK: begin
        if (running_q) begin
          if (match) begin
            tick_count_d = '0;
            if (!gap_phase_q) begin
              gap_phase_d    = 1'b1;
              compare_d      = extra_gap_i;
              evt_o.char_gap = 1'b1;
            end else begin
              gap_phase_d     = 1'b0;
              running_d       = 1'b0;
              evt_o.frame_end = 1'b1;
            end
          end else begin
            tick_count_d = count_inc;
          end
        end
      end
      CMD_TX_START: begin
        gap_phase_d = 1'b0;
        running_d   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // State registers, updated only when a beat is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_phase_q  <= 1'b0;
      running_q    <= 1'b0;
      tick_count_q <= '0;
      compare_q    <= 16'd1718;
    end else if (step_i) begin
      gap_phase_q  <= gap_phase_d;
      running_q    <= running_d;
      tick_count_q <= tick_count_d;
      compare_q    <= compare_d;
    end
  end

endmodule

// ----- design/rtu_frame_gap_detector_top.sv -----
// ----------------------------------------------------------------------------
// rtu_frame_gap_detector_top
// Receive-side RTU frame timing with receive buffer indexing.
// ----------------------------------------------------------------------------
// Every input beat (byte, tick, arm, disarm, transmit start) yields exactly one
// result beat. The block takes one beat per clock cycle as long as results are
// drained; each beat passes through one input stage register and one result
// register, with all the timer and buffer-index logic between them. Output
// stall backs up through the result register into the input stage, which then
// raises in_stall_o. Writes to the two gap registers take effect at the next
// byte (short gap) or the next 1.5 character match (extra gap); write them only
// while the block is idle.
// ----------------------------------------------------------------------------
module rtu_frame_gap_detector_top
  import rtu_gap_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_idx_i,
  input  logic [TICK_W-1:0] cfg_data_i,
  // input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [BYTE_W-1:0] rx_data_i,
  input  logic              framing_err_i,
  input  logic              parity_err_i,
  input  logic              overrun_err_i,
  // output channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              store_valid_o,
  output logic [IDX_W-1:0]  store_index_o,
  output logic [BYTE_W-1:0] store_byte_o,
  output logic              char_gap_event_o,
  output logic              frame_end_event_o,
  output logic              frame_error_event_o,
  output logic              overflow_flag_o,
  output logic [LEN_W-1:0]  frame_length_o
);

  logic [TICK_W-1:0] short_gap_q, extra_gap_q;
  logic              in_vld_q;
  logic [CMD_W-1:0]  cmd_q;
  logic [BYTE_W-1:0] data_q;
  logic              line_err_q;
  logic              out_vld_q;
  res_t              res_q, res_d;
  logic              rx_armed_q, rx_armed_d;
  logic [LEN_W-1:0]  rx_len_q, rx_len_d;
  logic              out_free, advance, in_accept;
  cmd_e              cmd;
  tmr_evt_t          tmr_evt;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_gap_q <= 16'd1718;
      extra_gap_q <= 16'd2290;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SHORT_GAP: short_gap_q <= cfg_data_i;
        REG_EXTRA_GAP: extra_gap_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Handshake: result slot frees when empty or being taken
  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q      <= command_i;
      data_q     <= rx_data_i;
      line_err_q <= framing_err_i | parity_err_i | overrun_err_i;
    end
  end

  assign cmd = cmd_e'(cmd_q);

  // Gap timer
  rtu_gap_timer u_timer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .cmd_i       (cmd),
    .short_gap_i (short_gap_q),
    .extra_gap_i (extra_gap_q),
    .evt_o       (tmr_evt)
  );

  // Reception control and result assembly
  always_comb begin
    rx_armed_d              = rx_armed_q;
    rx_len_d                = rx_len_q;
    res_d                   = '0;
    res_d.char_gap_event    = tmr_evt.char_gap;
    res_d.frame_end_event   = tmr_evt.frame_end;
    case (cmd)
      CMD_RX_BYTE: begin
        if (line_err_q) begin
          res_d.frame_error_event = 1'b1;
        end else begin
          if (rx_armed_q) begin
            if (rx_len_q < LEN_W'(BUF_DEPTH)) begin
              res_d.store_valid = 1'b1;
              res_d.store_index = rx_len_q[IDX_W-1:0];
              res_d.store_byte  = data_q;
              rx_len_d          = rx_len_q + LEN_W'(1);
            end else begin
              res_d.overflow_flag = 1'b1;
            end
          end
          res_d.frame_error_event = tmr_evt.in_window;
        end
      end
      CMD_ARM: begin
        rx_armed_d = 1'b1;
        rx_len_d   = '0;
      end
      CMD_DISARM: begin
        rx_armed_d = 1'b0;
      end
      default: begin
      end
    endcase
    res_d.frame_length = rx_len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_armed_q <= 1'b0;
      rx_len_q   <= '0;
    end else if (advance) begin
      rx_armed_q <= rx_armed_d;
      rx_len_q   <= rx_len_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= advance || (out_vld_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign store_valid_o       = res_q.store_valid;
  assign store_index_o       = res_q.store_index;
  assign store_byte_o        = res_q.store_byte;
  assign char_gap_event_o    = res_q.char_gap_event;
  assign frame_end_event_o   = res_q.frame_end_event;
  assign frame_error_event_o = res_q.frame_error_event;
  assign overflow_flag_o     = res_q.overflow_flag;
  assign frame_length_o      = res_q.frame_length;

  // Checks
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (res_q.frame_length <= LEN_W'(BUF_DEPTH)))
    else $error("frame length beyond buffer depth");

  a_store_xor_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(res_q.store_valid && res_q.overflow_flag))
    else $error("byte both stored and dropped");

  a_gap_events: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(res_q.char_gap_event && res_q.frame_end_event))
    else $error("both gap events in one beat");

  a_store_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.store_valid) |->
      (res_q.frame_length == ({1'b0, res_q.store_index} + LEN_W'(1))))
    else $error("store index does not track frame length");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && out_vld_q && out_stall_i))
    else $error("input stalled with room in the pipeline");

endmodule
